>>> hdl/tlpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpf_pkg
// Shared types and codes of the three-level strict-priority queue.
// ----------------------------------------------------------------------------
package tlpf_pkg;

  localparam int NUM_LEVELS = 3;

  typedef logic [1:0] lvl_t;

  localparam lvl_t LVL_LOW  = 2'd0;
  localparam lvl_t LVL_HIGH = 2'd1;
  localparam lvl_t LVL_TOP  = 2'd2;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_CLR = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

>>> hdl/three_level_priority_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_priority_fifo
// Strict-priority queue of three FIFO levels with per-transaction status.
// ----------------------------------------------------------------------------
// One transaction is accepted every clock cycle while out_ready keeps the
// pipeline from stalling: pointers and counts update at the acceptance edge,
// the level stores (one memory per level, one write and two read ports,
// registered read data) deliver the removed head and the new head alongside
// the first stage, and the output register holds the result until it is
// taken. The newest entry of each level is kept in a tail register, so no
// store read is spent on it. Stores are not cleared by reset or by the clear
// command; only queued entries are ever used.
module three_level_priority_fifo #(
  parameter int LEVEL_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [1:0]                               in_cmd,
  input  logic signed [VALUE_WIDTH-1:0]            in_data_in,
  input  logic [1:0]                               in_level,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [1:0]                               out_status,
  output logic signed [VALUE_WIDTH-1:0]            out_data_out,
  output logic signed [VALUE_WIDTH-1:0]            out_first_value,
  output logic signed [VALUE_WIDTH-1:0]            out_last_value,
  output logic [$clog2(3*LEVEL_DEPTH+1)-1:0]       out_total_count,
  output logic [tlpf_pkg::NUM_LEVELS-1:0]          out_empty_mask,
  output logic [tlpf_pkg::NUM_LEVELS-1:0]          out_full_mask
);

  import tlpf_pkg::*;

  localparam int PtrW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CntW = $clog2(LEVEL_DEPTH + 1);
  localparam int TotW = $clog2(3 * LEVEL_DEPTH + 1);

  typedef logic [PtrW-1:0]        ptr_t;
  typedef logic [CntW-1:0]        cnt_t;
  typedef logic [TotW-1:0]        tot_t;
  typedef logic [VALUE_WIDTH-1:0] val_t;

  function automatic ptr_t bump(input ptr_t p);
    return (p == ptr_t'(LEVEL_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  // queue state
  ptr_t rp_r   [NUM_LEVELS];
  ptr_t rp_nxt [NUM_LEVELS];
  ptr_t wp_r   [NUM_LEVELS];
  ptr_t wp_nxt [NUM_LEVELS];
  cnt_t cnt_r  [NUM_LEVELS];
  cnt_t cnt_nxt[NUM_LEVELS];
  val_t tail_r [NUM_LEVELS];
  val_t tail_nxt[NUM_LEVELS];
  tot_t total_r;
  tot_t total_nxt;

  // store read data
  val_t rd_head_r[NUM_LEVELS];
  val_t rd_next_r[NUM_LEVELS];

  // first stage
  logic    s1_valid_r;
  status_t s1_status_r;
  lvl_t    s1_tb_r;
  logic    s1_deq_r;
  lvl_t    s1_ta_r;
  logic    s1_any_r;
  logic    s1_byp_r;
  val_t    s1_data_r;
  val_t    s1_last_r;
  tot_t    s1_total_r;
  logic [NUM_LEVELS-1:0] s1_empty_r;
  logic [NUM_LEVELS-1:0] s1_full_r;

  // output register
  logic    out_valid_r;
  status_t out_status_r;
  val_t    out_data_out_r;
  val_t    out_first_r;
  val_t    out_last_r;
  tot_t    out_total_r;
  logic [NUM_LEVELS-1:0] out_empty_r;
  logic [NUM_LEVELS-1:0] out_full_r;

  // combinational step
  logic    accept;
  logic    s1_adv;
  lvl_t    lv;
  lvl_t    tb;
  logic    any_b;
  lvl_t    ta;
  logic    any_a;
  logic    wr_en;
  logic    deq_ok;
  logic    byp;
  status_t status;
  val_t    last_val;
  logic [NUM_LEVELS-1:0] empty_nxt;
  logic [NUM_LEVELS-1:0] full_nxt;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lv = (in_level > LVL_TOP) ? LVL_TOP : in_level;

    tb    = LVL_LOW;
    any_b = 1'b1;
    priority if (cnt_r[LVL_TOP] != '0) begin
      tb = LVL_TOP;
    end else if (cnt_r[LVL_HIGH] != '0) begin
      tb = LVL_HIGH;
    end else if (cnt_r[LVL_LOW] != '0) begin
      tb = LVL_LOW;
    end else begin
      any_b = 1'b0;
    end

    for (int i = 0; i < NUM_LEVELS; i++) begin
      rp_nxt[i]   = rp_r[i];
      wp_nxt[i]   = wp_r[i];
      cnt_nxt[i]  = cnt_r[i];
      tail_nxt[i] = tail_r[i];
    end
    total_nxt = total_r;
    status    = ST_OK;
    wr_en     = 1'b0;
    deq_ok    = 1'b0;

    unique case (cmd_t'(in_cmd))
      CMD_ENQ: begin
        if (cnt_r[lv] == cnt_t'(LEVEL_DEPTH)) begin
          status = ST_FULL;
        end else begin
          wr_en        = 1'b1;
          wp_nxt[lv]   = bump(wp_r[lv]);
          cnt_nxt[lv]  = cnt_r[lv] + cnt_t'(1);
          tail_nxt[lv] = in_data_in;
          total_nxt    = total_r + tot_t'(1);
        end
      end
      CMD_DEQ: begin
        if (!any_b) begin
          status = ST_EMPTY;
        end else begin
          deq_ok      = 1'b1;
          rp_nxt[tb]  = bump(rp_r[tb]);
          cnt_nxt[tb] = cnt_r[tb] - cnt_t'(1);
          total_nxt   = total_r - tot_t'(1);
        end
      end
      CMD_CLR: begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          rp_nxt[i]  = '0;
          wp_nxt[i]  = '0;
          cnt_nxt[i] = '0;
        end
        total_nxt = '0;
      end
      CMD_NOP: begin
      end
      default: begin
      end
    endcase

    ta    = LVL_LOW;
    any_a = 1'b1;
    priority if (cnt_nxt[LVL_TOP] != '0) begin
      ta = LVL_TOP;
    end else if (cnt_nxt[LVL_HIGH] != '0) begin
      ta = LVL_HIGH;
    end else if (cnt_nxt[LVL_LOW] != '0) begin
      ta = LVL_LOW;
    end else begin
      any_a = 1'b0;
    end

    // new head is the entry written in this transaction
    byp      = wr_en && (cnt_r[lv] == '0) && (ta == lv);
    last_val = any_a ? tail_nxt[ta] : '0;

    for (int i = 0; i < NUM_LEVELS; i++) begin
      empty_nxt[i] = (cnt_nxt[i] == '0);
      full_nxt[i]  = (cnt_nxt[i] == cnt_t'(LEVEL_DEPTH));
    end
  end

  // level stores
  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
    val_t store_r [LEVEL_DEPTH];

    always_ff @(posedge clk) begin
      if (accept && wr_en && (lv == lvl_t'(g))) begin
        store_r[wp_r[g]] <= in_data_in;
      end
      if (accept) begin
        rd_head_r[g] <= store_r[rp_r[g]];
        rd_next_r[g] <= store_r[rp_nxt[g]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        rp_r[i]  <= '0;
        wp_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
      total_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          rp_r[i]  <= rp_nxt[i];
          wp_r[i]  <= wp_nxt[i];
          cnt_r[i] <= cnt_nxt[i];
        end
        total_r <= total_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        tail_r[i] <= tail_nxt[i];
      end
      s1_status_r <= status;
      s1_tb_r     <= tb;
      s1_deq_r    <= deq_ok;
      s1_ta_r     <= ta;
      s1_any_r    <= any_a;
      s1_byp_r    <= byp;
      s1_data_r   <= in_data_in;
      s1_last_r   <= last_val;
      s1_total_r  <= total_nxt;
      s1_empty_r  <= empty_nxt;
      s1_full_r   <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r   <= s1_status_r;
      out_data_out_r <= s1_deq_r ? rd_head_r[s1_tb_r] : '0;
      out_first_r    <= !s1_any_r ? '0 : (s1_byp_r ? s1_data_r : rd_next_r[s1_ta_r]);
      out_last_r     <= s1_last_r;
      out_total_r    <= s1_total_r;
      out_empty_r    <= s1_empty_r;
      out_full_r     <= s1_full_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_out    = out_data_out_r;
  assign out_first_value = out_first_r;
  assign out_last_value  = out_last_r;
  assign out_total_count = out_total_r;
  assign out_empty_mask  = out_empty_r;
  assign out_full_mask   = out_full_r;

  // total matches the per-level counts
  a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
    total_r == tot_t'(cnt_r[0]) + tot_t'(cnt_r[1]) + tot_t'(cnt_r[2]))
    else $error("total count out of step with level counts");

  // no level ever holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= cnt_t'(LEVEL_DEPTH)) && (cnt_r[1] <= cnt_t'(LEVEL_DEPTH)) &&
    (cnt_r[2] <= cnt_t'(LEVEL_DEPTH)))
    else $error("level count beyond depth");

  // clear empties every level
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd == CMD_CLR) |=> (total_r == '0))
    else $error("clear left entries behind");

  // an empty refusal only reports a fully empty queue
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |->
      (out_total_count == '0) && (out_empty_mask == '1))
    else $error("empty refusal with entries present");

  // stall only when both pipeline registers hold a transaction
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with room in the pipeline");

endmodule
